// File: src/tsts_pkg.sv
`default_nettype none

package tsts_pkg;

    // field widths of the request and result transfers
    localparam int REQ_TYPE_W   = 2;
    localparam int INDEX_W      = 8;
    localparam int TICK_FIELD_W = 32;
    localparam int FIRED_IDX_W  = 4;
    localparam int SLOTS_W      = 5;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_SLOTS_IN_USE = 1'b0;
    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_START   = 2'd0,
        REQ_CANCEL  = 2'd1,
        REQ_PROCESS = 2'd2,
        REQ_NONE    = 2'd3
    } t_req_e;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state_e;

    typedef struct packed {
        logic                   status;
        logic                   fired;
        logic [FIRED_IDX_W-1:0] fired_index;
        logic                   last;
    } t_result;

endpackage

`default_nettype wire

// File: src/tsts_req_if.sv
`default_nettype none

interface tsts_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [tsts_pkg::REQ_TYPE_W-1:0]      req_type;
    logic [tsts_pkg::INDEX_W-1:0]         index;
    logic [tsts_pkg::TICK_FIELD_W-1:0]    now;
    logic [tsts_pkg::TICK_FIELD_W-1:0]    delay;

    modport source (output valid, req_type, index, now, delay, input ready);
    modport sink   (input valid, req_type, index, now, delay, output ready);
endinterface

`default_nettype wire

// File: src/tsts_res_if.sv
`default_nettype none

interface tsts_res_if;
    logic                               valid;
    logic                               ready;
    logic                               status;
    logic                               fired;
    logic [tsts_pkg::FIRED_IDX_W-1:0]   fired_index;
    logic                               last;

    modport source (output valid, status, fired, fired_index, last, input ready);
    modport sink   (input valid, status, fired, fired_index, last, output ready);
endinterface

`default_nettype wire

// File: src/timer_slot_table_scan.sv
// Channel   Dir  Payload                              Transfer when
// i_req     in   req_type, index, now, delay          i_req.valid && i_req.ready
// o_res     out  status, fired, fired_index, last     o_res.valid && o_res.ready
// APB cfg   in   slots_in_use at byte 0               psel && penable && pwrite
//
// Start, cancel and the unused code load their result into the output
// register when taken; it is valid there from the next cycle on.
// Process reads one deadline a cycle from the slot memory into a compare
// stage; a stalled output holds the scan only once a second expired slot
// is waiting behind the one already held.
// Requests are taken only in idle with the output register free.
// Reset clears the armed flags and the control state; deadlines are not
// cleared (a deadline counts only once its slot is armed, and arming
// writes it), so no clearing pass is needed.

`default_nettype none

module timer_slot_table_scan #(
    parameter int SLOT_COUNT = 16,
    parameter int TICK_BITS  = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    tsts_req_if.sink                              i_req,
    tsts_res_if.source                            o_res,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [tsts_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire  [tsts_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tsts_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam logic [tsts_pkg::INDEX_W-1:0] SLOT_COUNT_8 =
        tsts_pkg::INDEX_W'(SLOT_COUNT);

    // ---------------- configuration ----------------
    logic [tsts_pkg::SLOTS_W-1:0] r_slots;
    logic                         cfg_wr;
    logic                         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == tsts_pkg::REG_SLOTS_IN_USE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_sel ? tsts_pkg::APB_DATA_W'(r_slots) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= tsts_pkg::SLOTS_RESET;
        end else if (cfg_wr && cfg_sel) begin
            r_slots <= pwdata[tsts_pkg::SLOTS_W-1:0];
        end
    end

    // live slot count, saturated to the table size
    logic [tsts_pkg::INDEX_W-1:0] cap8;
    always_comb begin
        if (tsts_pkg::INDEX_W'(r_slots) > SLOT_COUNT_8) begin
            cap8 = SLOT_COUNT_8;
        end else begin
            cap8 = tsts_pkg::INDEX_W'(r_slots);
        end
    end

    // ---------------- state ----------------
    tsts_pkg::t_state_e r_state, n_state;

    logic [SLOT_COUNT-1:0]  r_armed;
    logic [TICK_BITS-1:0]   deadline_mem [SLOT_COUNT];
    logic [TICK_BITS-1:0]   r_rd_data;      // memory read register = compare stage data

    logic [TICK_BITS-1:0]   r_now;
    logic [CNT_W-1:0]       r_scan_idx;     // next slot to read
    logic                   r_cmp_vld;
    logic [SLOT_W-1:0]      r_cmp_idx;
    logic                   r_pend_vld;     // expired slot held until we know if it is last
    logic [SLOT_W-1:0]      r_pend_idx;

    logic                   r_out_vld;
    tsts_pkg::t_result      r_out;

    // ---------------- datapath terms ----------------
    logic                   req_acc;
    logic                   out_free;
    logic                   idx_ok;
    logic [SLOT_W-1:0]      req_slot;
    logic [TICK_BITS-1:0]   req_now;
    logic [TICK_BITS-1:0]   req_deadline;
    logic [TICK_BITS-1:0]   diff;
    logic                   expired;
    logic                   issuing;
    logic                   scan_end;

    assign out_free     = !r_out_vld || o_res.ready;
    assign req_acc      = i_req.valid && i_req.ready;
    assign idx_ok       = (i_req.index < cap8);
    assign req_slot     = i_req.index[SLOT_W-1:0];
    assign req_now      = TICK_BITS'(i_req.now);
    assign req_deadline = req_now + TICK_BITS'(i_req.delay);

    // wrap-safe: expired when now - deadline is not negative
    assign diff     = r_now - r_rd_data;
    assign expired  = r_cmp_vld && r_armed[r_cmp_idx] && !diff[TICK_BITS-1];
    assign issuing  = (r_state == tsts_pkg::ST_SCAN) &&
                      (tsts_pkg::INDEX_W'(r_scan_idx) < cap8);
    assign scan_end = (r_state == tsts_pkg::ST_SCAN) && !issuing && !r_cmp_vld;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsts_pkg::ST_IDLE: begin
                if (req_acc && i_req.req_type == tsts_pkg::REQ_PROCESS) begin
                    n_state = tsts_pkg::ST_SCAN;
                end
            end
            tsts_pkg::ST_SCAN: begin
                if (scan_end && out_free) begin
                    n_state = tsts_pkg::ST_IDLE;
                end
            end
            default: n_state = tsts_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    logic              in_ready;
    logic              stall;
    logic              rd_en;
    logic              mem_we;
    logic              arm_set;
    logic              arm_clr;
    logic [SLOT_W-1:0] arm_idx;
    logic              ld_out;
    tsts_pkg::t_result out_data;

    always_comb begin
        in_ready = 1'b0;
        stall    = 1'b0;
        rd_en    = 1'b0;
        mem_we   = 1'b0;
        arm_set  = 1'b0;
        arm_clr  = 1'b0;
        arm_idx  = req_slot;
        ld_out   = 1'b0;
        out_data = '{status: tsts_pkg::STATUS_OK, fired: 1'b0,
                     fired_index: '0, last: 1'b1};
        case (r_state)
            tsts_pkg::ST_IDLE: begin
                in_ready = out_free;
                if (req_acc) begin
                    case (i_req.req_type)
                        tsts_pkg::REQ_START, tsts_pkg::REQ_CANCEL: begin
                            ld_out = 1'b1;
                            if (!idx_ok) begin
                                out_data.status = tsts_pkg::STATUS_BAD_INDEX;
                            end else if (i_req.req_type == tsts_pkg::REQ_START) begin
                                mem_we  = 1'b1;
                                arm_set = 1'b1;
                            end else begin
                                arm_clr = 1'b1;
                            end
                        end
                        tsts_pkg::REQ_NONE: ld_out = 1'b1;
                        default: ;
                    endcase
                end
            end
            tsts_pkg::ST_SCAN: begin
                // a second expiry needs the output register for the held one
                stall   = expired && r_pend_vld && !out_free;
                rd_en   = issuing && !stall;
                arm_idx = r_cmp_idx;
                arm_clr = expired && !stall;
                if (expired && r_pend_vld && out_free) begin
                    ld_out               = 1'b1;
                    out_data.fired       = 1'b1;
                    out_data.fired_index = tsts_pkg::FIRED_IDX_W'(r_pend_idx);
                    out_data.last        = 1'b0;
                end else if (scan_end && out_free) begin
                    ld_out         = 1'b1;
                    out_data.fired = r_pend_vld;
                    if (r_pend_vld) begin
                        out_data.fired_index = tsts_pkg::FIRED_IDX_W'(r_pend_idx);
                    end
                end
            end
            default: ;
        endcase
    end

    assign i_req.ready       = in_ready;
    assign o_res.valid       = r_out_vld;
    assign o_res.status      = r_out.status;
    assign o_res.fired       = r_out.fired;
    assign o_res.fired_index = r_out.fired_index;
    assign o_res.last        = r_out.last;

    // ---------------- slot memory ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            deadline_mem[req_slot] <= req_deadline;
        end
        if (rd_en) begin
            r_rd_data <= deadline_mem[r_scan_idx[SLOT_W-1:0]];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tsts_pkg::ST_IDLE;
            r_armed    <= '0;
            r_cmp_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (arm_set) begin
                r_armed[arm_idx] <= 1'b1;
            end else if (arm_clr) begin
                r_armed[arm_idx] <= 1'b0;
            end

            if (ld_out) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end

            if (r_state == tsts_pkg::ST_IDLE) begin
                r_cmp_vld  <= 1'b0;
                r_pend_vld <= 1'b0;
            end else begin
                if (!stall) begin
                    r_cmp_vld <= issuing;
                end
                if (expired && !stall) begin
                    r_pend_vld <= 1'b1;
                end else if (scan_end && out_free) begin
                    r_pend_vld <= 1'b0;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out <= out_data;
        end
        if (req_acc) begin
            r_now      <= req_now;
            r_scan_idx <= '0;
        end else if (rd_en) begin
            r_scan_idx <= r_scan_idx + CNT_W'(1);
        end
        if (!stall) begin
            r_cmp_idx <= r_scan_idx[SLOT_W-1:0];
        end
        if (expired && !stall) begin
            r_pend_idx <= r_cmp_idx;
        end
    end

    // ---------------- assertions ----------------
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsts_pkg::ST_IDLE) |-> (!r_cmp_vld && !r_pend_vld))
        else $error("scan stage busy while idle");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsts_pkg::ST_SCAN) |-> (tsts_pkg::INDEX_W'(r_scan_idx) <= cap8))
        else $error("scan ran past the live slots");

    a_expiry_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (expired && !stall) |=> !r_armed[$past(r_cmp_idx)])
        else $error("expired slot still armed");

    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsts_pkg::ST_SCAN) |-> !i_req.ready)
        else $error("request taken during a scan");

endmodule

`default_nettype wire

// File: tb/sv/timer_table_checker.sv
`timescale 1ns / 1ps

module timer_table_checker #(
    parameter int SLOT_COUNT = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    tsts_req_if                              i_req,
    tsts_res_if                              i_res,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [tsts_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire [tsts_pkg::APB_DATA_W-1:0]   pwdata,
    input  wire                              pready,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_fired
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic                              armed [SLOT_COUNT];
    logic [tsts_pkg::TICK_FIELD_W-1:0] deadline [SLOT_COUNT];
    logic [tsts_pkg::SLOTS_W-1:0]      slots_reg;
    tsts_pkg::t_result                 awaited_results [$];

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // expected transfers for one request; updates the slot table as it goes
    task automatic apply_request(input tsts_pkg::t_req_e kind,
                                 input logic [tsts_pkg::INDEX_W-1:0] idx,
                                 input logic [tsts_pkg::TICK_FIELD_W-1:0] now,
                                 input logic [tsts_pkg::TICK_FIELD_W-1:0] delay);
        int span;
        int n;
        int s;
        logic [SLOT_W-1:0] slot;
        tsts_pkg::t_result r;
        logic [tsts_pkg::TICK_FIELD_W-1:0] lag;
        span = (int'(slots_reg) > SLOT_COUNT) ? SLOT_COUNT : int'(slots_reg);
        slot = idx[SLOT_W-1:0];
        r.status      = tsts_pkg::STATUS_OK;
        r.fired       = 1'b0;
        r.fired_index = '0;
        r.last        = 1'b1;
        case (kind)
            tsts_pkg::REQ_START, tsts_pkg::REQ_CANCEL: begin
                if (int'(idx) >= span) begin
                    r.status = tsts_pkg::STATUS_BAD_INDEX;
                end else if (kind == tsts_pkg::REQ_START) begin
                    armed[slot]    = 1'b1;
                    deadline[slot] = now + delay;
                end else begin
                    armed[slot] = 1'b0;
                end
                awaited_results.push_back(r);
            end
            tsts_pkg::REQ_PROCESS: begin
                n = 0;
                for (s = 0; s < span; s++) begin
                    if (armed[s]) begin
                        lag = now - deadline[s];
                        // due when now - deadline is non-negative as a signed tick
                        if (!lag[tsts_pkg::TICK_FIELD_W-1]) begin
                            armed[s] = 1'b0;
                            r.fired       = 1'b1;
                            r.fired_index = tsts_pkg::FIRED_IDX_W'(s);
                            r.last        = 1'b0;
                            awaited_results.push_back(r);
                            n++;
                        end
                    end
                end
                if (n == 0) begin
                    awaited_results.push_back(r);
                end else begin
                    r = awaited_results.pop_back();
                    r.last = 1'b1;
                    awaited_results.push_back(r);
                end
            end
            default: begin
                awaited_results.push_back(r);
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        tsts_pkg::t_result got;
        tsts_pkg::t_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                armed[s] = 1'b0;
            end
            slots_reg = tsts_pkg::SLOTS_RESET;
            awaited_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_fired      = 0;
        end else begin
            // results first: a request can never produce a transfer in its own cycle
            if (i_res.valid && i_res.ready) begin
                got.status      = i_res.status;
                got.fired       = i_res.fired;
                got.fired_index = i_res.fired_index;
                got.last        = i_res.last;
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("unexpected result st=%0b fired=%0b idx=%0d last=%0b",
                                           got.status, got.fired, got.fired_index, got.last));
                end else begin
                    want = awaited_results.pop_front();
                    o_checked++;
                    if (got.fired === 1'b1) begin
                        o_fired++;
                    end
                    if (got !== want) begin
                        note_failure($sformatf(
                            "exp st=%0b fired=%0b idx=%0d last=%0b, got st=%0b fired=%0b idx=%0d last=%0b",
                            want.status, want.fired, want.fired_index, want.last,
                            got.status, got.fired, got.fired_index, got.last));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(tsts_pkg::t_req_e'(i_req.req_type), i_req.index,
                              i_req.now, i_req.delay);
            end
            if (psel && penable && pwrite && pready
                && paddr == tsts_pkg::APB_ADDR_W'(4 * tsts_pkg::REG_SLOTS_IN_USE)) begin
                slots_reg = pwdata[tsts_pkg::SLOTS_W-1:0];
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// File: tb/sv/timer_slot_table_scan_tb.sv
`timescale 1ns / 1ps

module timer_slot_table_scan_tb;

    localparam int SLOTS         = 16;
    localparam int HOLD_CYCLES   = 80;   // long receiver hold-off, fills the block
    localparam int SETTLE_CYCLES = 24;   // > one full scan plus the compare stage
    localparam int PHASE_ITEMS   = 16;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [tsts_pkg::APB_ADDR_W-1:0] paddr;
    logic [tsts_pkg::APB_DATA_W-1:0] pwdata;
    logic [tsts_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    tsts_req_if req_if();
    tsts_res_if res_if();

    int          fail_count;
    int          pending;
    int          checked;
    int          fired_seen;
    int          sent;
    int          live;        // slots the block currently honours
    int          hold_asks;   // bumped by stimulus, served by the receiver
    logic        calm;        // no idling on either side while set
    logic [31:0] tick;        // running tick for well-formed sequences

    timer_slot_table_scan #(
        .SLOT_COUNT (SLOTS),
        .TICK_BITS  (32)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    timer_table_checker #(
        .SLOT_COUNT (SLOTS)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fired      (fired_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random back-pressure, plus a long hold-off on request
    initial begin
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else begin
                res_if.ready = calm || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // one request transfer; valid is left high so back-to-back items need no gap
    task automatic push_req(input tsts_pkg::t_req_e kind,
                            input logic [tsts_pkg::INDEX_W-1:0] idx,
                            input logic [31:0] now, input logic [31:0] delay);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 15) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.req_type = kind;
        req_if.index    = idx;
        req_if.now      = now;
        req_if.delay    = delay;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sent++;
    endtask

    // stop offering and let every outstanding result drain
    task automatic quiesce();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of slots_in_use, upper data bits random (the register keeps 5)
    task automatic write_slots(input logic [tsts_pkg::SLOTS_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = tsts_pkg::APB_ADDR_W'(4 * tsts_pkg::REG_SLOTS_IN_USE);
        pwdata  = ($urandom() & ~32'h1F) | 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        live    = (int'(value) > SLOTS) ? SLOTS : int'(value);
    endtask

    // mostly well-formed traffic on valid slots with near deadlines,
    // some out-of-range indexes, and a share of pure noise
    task automatic random_item();
        int pick;
        logic [tsts_pkg::INDEX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        tick = tick + $urandom_range(0, 6);
        if (live == 0 || pick < 15) begin
            push_req(tsts_pkg::t_req_e'(tsts_pkg::REQ_TYPE_W'($urandom_range(0, 3))),
                     tsts_pkg::INDEX_W'($urandom()), $urandom(), $urandom());
        end else if (pick < 25) begin
            idx = tsts_pkg::INDEX_W'($urandom_range(live, 255));
            push_req(tsts_pkg::t_req_e'((pick < 20) ? tsts_pkg::REQ_START
                                                     : tsts_pkg::REQ_CANCEL),
                     idx, tick, $urandom());
        end else begin
            idx = tsts_pkg::INDEX_W'($urandom_range(0, live - 1));
            if (pick < 65) begin
                push_req(tsts_pkg::REQ_START, idx, tick, $urandom_range(0, 40));
            end else if (pick < 75) begin
                push_req(tsts_pkg::REQ_CANCEL, idx, tick, $urandom());
            end else begin
                push_req(tsts_pkg::REQ_PROCESS, tsts_pkg::INDEX_W'($urandom()), tick,
                         $urandom());
            end
        end
    endtask

    initial begin
        logic [tsts_pkg::SLOTS_W-1:0] slot_plan [8];
        int phase;
        int n;
        req_if.valid    = 1'b0;
        req_if.req_type = tsts_pkg::REQ_START;
        req_if.index    = '0;
        req_if.now      = '0;
        req_if.delay    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_rst_n    = 1'b0;
        calm       = 1'b0;
        hold_asks  = 0;
        sent       = 0;
        tick       = '0;
        live       = SLOTS;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part, slots_in_use at its reset value ----
        push_req(tsts_pkg::REQ_PROCESS, 8'd0, 32'd0, 32'd0);                // empty table
        push_req(tsts_pkg::REQ_START, 8'd0, 32'hFFFF_FFF0, 32'h20);         // deadline wraps
        push_req(tsts_pkg::REQ_START, 8'd15, 32'd5, 32'd0);                 // top slot, no delay
        push_req(tsts_pkg::REQ_START, 8'd7, 32'd0, 32'hFFFF_FFFF);          // largest delay
        push_req(tsts_pkg::REQ_START, 8'd16, 32'd1, 32'd1);                 // first bad index
        push_req(tsts_pkg::REQ_START, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // widest bad index
        push_req(tsts_pkg::REQ_CANCEL, 8'hFF, 32'd0, 32'd0);
        push_req(tsts_pkg::REQ_NONE, tsts_pkg::INDEX_W'($urandom()), $urandom(), $urandom());
        push_req(tsts_pkg::REQ_PROCESS, 8'd0, 32'd5, 32'd0);
        push_req(tsts_pkg::REQ_START, 8'd3, 32'd100, 32'd50);
        push_req(tsts_pkg::REQ_START, 8'd3, 32'd100, 32'd10);               // re-arm, earlier
        push_req(tsts_pkg::REQ_CANCEL, 8'd0, 32'd0, 32'd0);                 // armed slot
        push_req(tsts_pkg::REQ_CANCEL, 8'd5, 32'd0, 32'd0);                 // idle slot
        push_req(tsts_pkg::REQ_PROCESS, 8'hFF, 32'd109, 32'hFFFF_FFFF);     // one tick early
        push_req(tsts_pkg::REQ_PROCESS, 8'd0, 32'd110, 32'd0);              // exactly due
        push_req(tsts_pkg::REQ_START, 8'd1, 32'd0, 32'd0);
        push_req(tsts_pkg::REQ_PROCESS, 8'd0, 32'h8000_0000, 32'd0);        // lag 2^31: not due
        push_req(tsts_pkg::REQ_PROCESS, 8'd0, 32'h7FFF_FFFF, 32'd0);        // largest due lag

        // ---- random phases over several slot counts ----
        // 16, then the smallest, zero, above the table (saturates), and odd sizes
        slot_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd9, 5'd17,
                      tsts_pkg::SLOTS_W'($urandom_range(2, 15)), 5'd16};
        for (phase = 0; phase < 8; phase++) begin
            // every phase starts with the sender paused until all results are in
            quiesce();
            write_slots(slot_plan[phase]);
            if (phase == 3) begin
                tick = 32'hFFFF_FFE0;   // walk the ticks across the wrap
            end
            calm = (phase == 4);        // one stretch with no idling at all
            if (phase == 5) begin
                hold_asks++;            // receiver stalls while items keep coming
            end
            // arm every live slot and sweep them all: one transfer per slot
            if (live > 0 && (phase == 0 || phase == 3 || phase == 6)) begin
                for (n = 0; n < live; n++) begin
                    push_req(tsts_pkg::REQ_START, tsts_pkg::INDEX_W'(n), tick,
                             $urandom_range(0, 8));
                end
                tick = tick + 8;
                push_req(tsts_pkg::REQ_PROCESS, tsts_pkg::INDEX_W'($urandom()), tick,
                         $urandom());
            end
            n = (live == 0) ? 8 : PHASE_ITEMS;
            repeat (n) random_item();
        end
        calm = 1'b0;

        quiesce();
        $display("Covered: %0d requests, %0d results checked, %0d slot expiries reported",
                 sent, checked, fired_seen);
        $display("Slot counts 16, 1, 0, 31, 9, 17 and a random one; tick wrap and a long stall");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
src/tsts_pkg.sv
src/tsts_req_if.sv
src/tsts_res_if.sv
src/timer_slot_table_scan.sv
tb/sv/timer_table_checker.sv
tb/sv/timer_slot_table_scan_tb.sv
